FILE: hdl/ppat_pkg.sv
`timescale 1ns / 1ps

package ppat_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int TIME_BITS_DEF   = 16;
  localparam int ADDR_W          = 32;
  localparam int MAX_AGE_W       = 15;
  localparam int COUNT_W         = 7;
  localparam logic [MAX_AGE_W-1:0] MAX_AGE_RESET = 15'd120;
  localparam logic [COUNT_W-1:0]   COUNT_MAX     = 7'd127;

  typedef enum logic [1:0] {
    ACT_JOIN  = 2'd0,
    ACT_HELLO = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_TICK  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               ok;
    logic               was_present;
    logic [COUNT_W-1:0] expired_count;
  } result_t;

endpackage

FILE: hdl/ppat_ram.sv
`timescale 1ns / 1ps

module ppat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ppat_ctrl.sv
`timescale 1ns / 1ps

module ppat_ctrl #(
  parameter int TABLE_DEPTH = ppat_pkg::TABLE_DEPTH_DEF,
  parameter int TIME_BITS   = ppat_pkg::TIME_BITS_DEF,
  parameter int IDX_W       = $clog2(TABLE_DEPTH),
  parameter int WORD_W      = 1 + TIME_BITS + ppat_pkg::ADDR_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  ppat_pkg::action_t                action,
  input  logic [ppat_pkg::ADDR_W-1:0]      peer_addr,
  input  logic [ppat_pkg::MAX_AGE_W-1:0]   max_age,
  output logic                             busy,
  output logic                             ram_we,
  output logic [IDX_W-1:0]                 ram_waddr,
  output logic [WORD_W-1:0]                ram_wdata,
  output logic [IDX_W-1:0]                 ram_raddr,
  input  logic [WORD_W-1:0]                ram_rdata,
  output logic                             res_valid,
  output ppat_pkg::result_t                res
);

  localparam int CMP_W = (TIME_BITS > ppat_pkg::MAX_AGE_W) ? TIME_BITS : ppat_pkg::MAX_AGE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  ppat_pkg::state_t  state_r, state_nxt;
  ppat_pkg::action_t act_r;
  logic [ppat_pkg::ADDR_W-1:0]   addr_r;
  logic [TIME_BITS-1:0]          now_r;
  logic [IDX_W-1:0]              rd_idx_r, chk_idx_r, hit_idx_r, free_idx_r;
  logic                          rd_pend_r, found_r, free_found_r, res_valid_r;
  logic [ppat_pkg::COUNT_W-1:0]  cnt_r;
  ppat_pkg::result_t             res_r, res_nxt;

  logic                          rd_valid;
  logic [TIME_BITS-1:0]          rd_stamp, age;
  logic [ppat_pkg::ADDR_W-1:0]   rd_addr;
  logic                          expire, match, free;

  assign rd_valid = ram_rdata[WORD_W-1];
  assign rd_stamp = ram_rdata[WORD_W-2 -: TIME_BITS];
  assign rd_addr  = ram_rdata[ppat_pkg::ADDR_W-1:0];
  assign age      = now_r - rd_stamp;

  assign expire = rd_pend_r && (act_r == ppat_pkg::ACT_TICK) && rd_valid &&
                  (CMP_W'(age) >= CMP_W'(max_age));
  assign match  = rd_pend_r && (act_r != ppat_pkg::ACT_TICK) && rd_valid &&
                  (rd_addr == addr_r);
  assign free   = rd_pend_r && (act_r != ppat_pkg::ACT_TICK) && !rd_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppat_pkg::ST_CLEAR: if (rd_idx_r == LAST_IDX) state_nxt = ppat_pkg::ST_IDLE;
      ppat_pkg::ST_IDLE:  if (start) state_nxt = ppat_pkg::ST_SCAN;
      ppat_pkg::ST_SCAN:  if (rd_idx_r == LAST_IDX) state_nxt = ppat_pkg::ST_DRAIN;
      ppat_pkg::ST_DRAIN: state_nxt = ppat_pkg::ST_DONE;
      ppat_pkg::ST_DONE:  state_nxt = ppat_pkg::ST_IDLE;
      default:            state_nxt = ppat_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx_r;
    ram_wdata = {1'b0, ram_rdata[WORD_W-2:0]};
    ram_raddr = rd_idx_r;
    res_nxt   = res_r;
    unique case (state_r)
      ppat_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_idx_r;
        ram_wdata = '0;
      end
      ppat_pkg::ST_SCAN, ppat_pkg::ST_DRAIN: begin
        ram_we = expire;
      end
      ppat_pkg::ST_DONE: begin
        ram_wdata = {1'b1, now_r, addr_r};
        res_nxt.was_present   = found_r;
        res_nxt.expired_count = '0;
        unique case (act_r)
          ppat_pkg::ACT_JOIN: begin
            res_nxt.ok = found_r || free_found_r;
            ram_we     = !found_r && free_found_r;
            ram_waddr  = free_idx_r;
          end
          ppat_pkg::ACT_HELLO: begin
            res_nxt.ok = found_r;
            ram_we     = found_r;
            ram_waddr  = hit_idx_r;
          end
          ppat_pkg::ACT_QUERY: begin
            res_nxt.ok = found_r;
          end
          ppat_pkg::ACT_TICK: begin
            res_nxt.ok            = 1'b1;
            res_nxt.was_present   = 1'b0;
            res_nxt.expired_count = cnt_r;
          end
          default: res_nxt.ok = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ppat_pkg::ST_CLEAR;
      rd_idx_r     <= '0;
      rd_pend_r    <= 1'b0;
      res_valid_r  <= 1'b0;
      now_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= (state_r == ppat_pkg::ST_SCAN);
      res_valid_r <= (state_r == ppat_pkg::ST_DONE);
      chk_idx_r   <= rd_idx_r;
      res_r       <= res_nxt;
      unique case (state_r)
        ppat_pkg::ST_CLEAR, ppat_pkg::ST_SCAN: begin
          rd_idx_r <= (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
        end
        ppat_pkg::ST_IDLE: begin
          if (start) begin
            act_r        <= action;
            addr_r       <= peer_addr;
            rd_idx_r     <= '0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            cnt_r        <= '0;
            if (action == ppat_pkg::ACT_TICK) begin
              now_r <= now_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (match && !found_r) begin
        found_r   <= 1'b1;
        hit_idx_r <= chk_idx_r;
      end
      if (free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= chk_idx_r;
      end
      if (expire && (cnt_r != ppat_pkg::COUNT_MAX)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign busy      = (state_r != ppat_pkg::ST_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: hdl/peer_presence_aging_table.sv
`timescale 1ns / 1ps
// Channel   Ports                                     Handshake
// input     in_action, in_peer_addr                   start && !busy
// result    out_ok, out_was_present, out_expired_count out_strobe, one cycle
// config    cfg_wdata                                 cfg_we
//
// After the accepting edge the controller makes one pass over the table
// memory's single read port, a drain step and a write-back step, and
// out_strobe follows the write-back. busy drops with the strobe, so the next
// transaction can be accepted in the strobe cycle.
// After reset a clearing pass over every table entry runs with busy high.
// The receiver cannot stall; out_strobe lasts exactly one cycle.

module peer_presence_aging_table #(
  parameter int TABLE_DEPTH = ppat_pkg::TABLE_DEPTH_DEF,
  parameter int TIME_BITS   = ppat_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_action,
  input  logic [ppat_pkg::ADDR_W-1:0]        in_peer_addr,
  output logic                               out_strobe,
  output logic                               out_ok,
  output logic                               out_was_present,
  output logic [ppat_pkg::COUNT_W-1:0]       out_expired_count,
  input  logic                               cfg_we,
  input  logic [ppat_pkg::MAX_AGE_W-1:0]     cfg_wdata
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int WORD_W = 1 + TIME_BITS + ppat_pkg::ADDR_W;

  logic [ppat_pkg::MAX_AGE_W-1:0] max_age_r;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  ppat_pkg::result_t   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= ppat_pkg::MAX_AGE_RESET;
    end else if (cfg_we) begin
      max_age_r <= cfg_wdata;
    end
  end

  ppat_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TIME_BITS   (TIME_BITS),
    .IDX_W       (IDX_W),
    .WORD_W      (WORD_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (ppat_pkg::action_t'(in_action)),
    .peer_addr (in_peer_addr),
    .max_age   (max_age_r),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (out_strobe),
    .res       (res)
  );

  ppat_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_ok            = res.ok;
  assign out_was_present   = res.was_present;
  assign out_expired_count = res.expired_count;

endmodule

FILE: hdl/ppat_checker.sv
`timescale 1ns / 1ps

module ppat_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_strobe,
  input logic                         out_ok,
  input logic                         out_was_present,
  input logic [ppat_pkg::COUNT_W-1:0] out_expired_count
);

  // reset starts the clearing pass
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy && !$past(out_strobe))
    else $error("result strobe while busy or repeated");

  a_fail_no_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_ok |-> out_expired_count == '0)
    else $error("failed transaction reports expired entries");

  a_tick_not_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_expired_count != '0) |-> out_ok && !out_was_present)
    else $error("tick result flags inconsistent");

endmodule

bind peer_presence_aging_table ppat_checker u_ppat_checker (.*);
